@@ rtl/core/wrfb_pkg.sv @@
// Package for the wheel revolution frame builder.
// Holds the item structs, controller command/status structs and fixed constants.
// No dependencies.
package wrfb_pkg;

    localparam int unsigned FRAME_LEN   = 11;
    localparam int unsigned DIV_NUM_W   = 50;
    localparam int unsigned DIV_DEN_W   = 22;
    localparam int unsigned DIV_CNT_W   = 6;
    localparam int unsigned IDX_W       = 4;

    localparam logic [7:0]  FLAG_BYTE   = 8'h03;
    localparam logic [11:0] CIRC_MIN    = 12'd100;
    localparam logic [11:0] CIRC_RESET  = 12'd2105;
    localparam logic [15:0] MIN_SPEED   = 16'd10;
    localparam logic [7:0]  ROOM_MIN    = 8'd11;
    // e*1024/1000 == (e << 7) / 125; floor(e/125) == (e * TICK_MAGIC) >> TICK_SHIFT
    // for any 32-bit e
    localparam logic [28:0] TICK_MAGIC  = 29'd274877907;
    localparam int unsigned TICK_SHIFT  = 35;
    localparam logic [IDX_W-1:0] LAST_IDX = 4'(FRAME_LEN - 1);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [15:0] speed_centi_kmh;
        logic [15:0] crank_revs;
        logic [15:0] crank_time;
        logic [7:0]  room;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic accept;       // capture input item
        logic mul;          // form speed * elapsed and the tick quotient
        logic start_rev;    // start revolution division
        logic add_rev;      // add revolutions
        logic add_tick;     // add event ticks
        logic send;         // advance frame byte index
    } cmd_t;

    typedef struct packed {
        logic is_encode;
        logic room_ok;
        logic count_ok;     // update moves the wheel
        logic div_busy;
        logic last_byte;
    } status_t;

endpackage

@@ rtl/core/wheel_revolution_frame_builder.sv @@
// Top level of the wheel revolution frame builder.
// Depends on wrfb_pkg, wrfb_ctrl, wrfb_datapath (which holds wrfb_div).
//
// Usage:
//   in channel  : in_valid / in_stall / in_item. An item is taken at a clock edge
//                 with in_valid high and in_stall low.
//   out channel : out_valid / out_stall / out_item, one frame byte per item,
//                 last set on the eleventh byte.
//   cfg channel : cfg_valid / cfg_ready / cfg_data writes the wheel circumference
//                 (values below 100 act as 100). Write it only while idle.
// Timing:
//   Encode item with room >= 11: eleven bytes, one per cycle while the receiver
//   takes them; after acceptance ST_SEND loads each byte into the output
//   register. Room < 11: no bytes, next item taken in the following cycle.
//   Update item: ST_MUL, ST_CHECK, then idle if the wheel does not advance,
//   else one 50-step pass through the one-bit-per-cycle divider for the revolution
//   count; event ticks come from a reciprocal multiply. One item in work at a time.
// Reset clears the wheel counter, event time and timestamp, and loads 2105 mm.
// A stall on the out channel holds the current byte; the frame resumes after it.
module wheel_revolution_frame_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  wrfb_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output wrfb_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [11:0]          cfg_data
);

    wrfb_pkg::cmd_t      cmd;
    wrfb_pkg::status_t   status;
    wrfb_pkg::out_item_t frame_item;

    logic                out_valid_reg, out_valid_next;
    wrfb_pkg::out_item_t out_item_reg;
    logic                out_free;

    // The output register can take a byte when empty or when it drains this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    wrfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    wrfb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .in_item    (in_item),
        .cmd        (cmd),
        .status     (status),
        .frame_item (frame_item)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.send)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the next frame byte; hold it while stalled.
    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            out_item_reg <= frame_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/core/wrfb_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on wrfb_pkg for widths.
module wrfb_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [wrfb_pkg::DIV_NUM_W-1:0]  num,
    input  logic [wrfb_pkg::DIV_DEN_W-1:0]  den,
    output logic                            busy,
    output logic [wrfb_pkg::DIV_NUM_W-1:0]  quot
);

    localparam logic [wrfb_pkg::DIV_CNT_W-1:0] LastCnt =
        wrfb_pkg::DIV_CNT_W'(wrfb_pkg::DIV_NUM_W - 1);

    logic [wrfb_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [wrfb_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [wrfb_pkg::DIV_DEN_W-1:0] den_reg;
    logic [wrfb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic [wrfb_pkg::DIV_DEN_W:0]   trial;
    logic [wrfb_pkg::DIV_DEN_W:0]   diff;
    logic                           ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[wrfb_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            num_next  = num;
            cnt_next  = LastCnt;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[wrfb_pkg::DIV_DEN_W-1:0] : trial[wrfb_pkg::DIV_DEN_W-1:0];
            num_next = {num_reg[wrfb_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

@@ rtl/core/wrfb_datapath.sv @@
// Datapath: circumference register, wheel state, multipliers, revolution divider
// and frame byte select. Depends on wrfb_pkg and wrfb_div.
module wrfb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [11:0]          cfg_data,
    input  wrfb_pkg::in_item_t   in_item,
    input  wrfb_pkg::cmd_t       cmd,
    output wrfb_pkg::status_t    status,
    output wrfb_pkg::out_item_t  frame_item
);

    logic [11:0] circ_reg;
    logic [31:0] wheel_revs_reg;
    logic [15:0] wheel_event_time_reg;
    logic [31:0] last_update_ms_reg;

    logic [31:0] elapsed_reg;
    logic [15:0] speed_reg;
    logic        go_reg;
    logic [47:0] se_reg;
    logic [8:0]  tick_q_reg;
    logic [15:0] crank_revs_reg;
    logic [15:0] crank_time_reg;
    logic [wrfb_pkg::IDX_W-1:0] idx_reg;

    logic [11:0] circ_eff;
    logic [50:0] se_x5;
    logic [15:0] circ_x9;
    logic [wrfb_pkg::DIV_NUM_W-1:0] rev_num;
    logic [wrfb_pkg::DIV_DEN_W-1:0] rev_den;
    logic                           div_start;
    logic                           div_busy;
    logic [wrfb_pkg::DIV_NUM_W-1:0] div_quot;
    logic [60:0]                    tick_prod;
    logic [16:0]                    tick_q125;
    logic [7:0]                     tick_rem;
    logic [8:0]                     tick_rem_x3;
    logic [15:0]                    tick_add;
    logic [7:0]                     byte_sel;

    always_comb
    begin
        circ_eff = (circ_reg < wrfb_pkg::CIRC_MIN) ? wrfb_pkg::CIRC_MIN : circ_reg;
        se_x5    = {1'b0, se_reg, 2'b00} + {3'b000, se_reg};
        circ_x9  = {1'b0, circ_eff, 3'b000} + {4'b0000, circ_eff};
        rev_num  = {1'b0, se_reg, 1'b0} + ({38'd0, circ_eff} * 50'd360);
        rev_den  = {10'd0, circ_eff} * 22'd720;
    end

    // Event ticks: e = 125q + r gives floor(128e/125) = 128q + r + floor(3r/125).
    // Only the low 16 bits are kept, so q is needed mod 2^9 and r < 125 fits 8 bits.
    always_comb
    begin
        tick_prod   = {29'd0, elapsed_reg} * {32'd0, wrfb_pkg::TICK_MAGIC};
        tick_q125   = {8'd0, tick_q_reg} * 17'd125;
        tick_rem    = elapsed_reg[7:0] - tick_q125[7:0];
        tick_rem_x3 = {1'b0, tick_rem} + {tick_rem, 1'b0};
        tick_add    = {tick_q_reg, 7'b0000000} + {8'd0, tick_rem} +
                      ((tick_rem_x3 >= 9'd250) ? 16'd2 :
                       (tick_rem_x3 >= 9'd125) ? 16'd1 : 16'd0);
        div_start   = cmd.start_rev;
    end

    wrfb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rev_num),
        .den   (rev_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg             <= wrfb_pkg::CIRC_RESET;
            wheel_revs_reg       <= '0;
            wheel_event_time_reg <= '0;
            last_update_ms_reg   <= '0;
            idx_reg              <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                circ_reg <= cfg_data;
            end
            if (cmd.accept && (in_item.op == wrfb_pkg::OP_UPDATE))
            begin
                last_update_ms_reg <= in_item.now_ms;
            end
            if (cmd.add_rev)
            begin
                wheel_revs_reg <= wheel_revs_reg + div_quot[31:0];
            end
            if (cmd.add_tick)
            begin
                wheel_event_time_reg <= wheel_event_time_reg + tick_add;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.send)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elapsed_reg    <= in_item.now_ms - last_update_ms_reg;
            speed_reg      <= in_item.speed_centi_kmh;
            go_reg         <= (in_item.speed_centi_kmh >= wrfb_pkg::MIN_SPEED) &&
                              (in_item.now_ms > last_update_ms_reg);
            crank_revs_reg <= in_item.crank_revs;
            crank_time_reg <= in_item.crank_time;
        end
        if (cmd.mul)
        begin
            se_reg     <= {32'd0, speed_reg} * {16'd0, elapsed_reg};
            tick_q_reg <= tick_prod[wrfb_pkg::TICK_SHIFT+8:wrfb_pkg::TICK_SHIFT];
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            4'd0:    byte_sel = wrfb_pkg::FLAG_BYTE;
            4'd1:    byte_sel = wheel_revs_reg[7:0];
            4'd2:    byte_sel = wheel_revs_reg[15:8];
            4'd3:    byte_sel = wheel_revs_reg[23:16];
            4'd4:    byte_sel = wheel_revs_reg[31:24];
            4'd5:    byte_sel = wheel_event_time_reg[7:0];
            4'd6:    byte_sel = wheel_event_time_reg[15:8];
            4'd7:    byte_sel = crank_revs_reg[7:0];
            4'd8:    byte_sel = crank_revs_reg[15:8];
            4'd9:    byte_sel = crank_time_reg[7:0];
            4'd10:   byte_sel = crank_time_reg[15:8];
            default: byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        frame_item.out_byte = byte_sel;
        frame_item.last     = (idx_reg == wrfb_pkg::LAST_IDX);
        status.is_encode    = (in_item.op == wrfb_pkg::OP_ENCODE);
        status.room_ok      = (in_item.room >= wrfb_pkg::ROOM_MIN);
        status.count_ok     = go_reg && (se_x5 > {35'd0, circ_x9});
        status.div_busy     = div_busy;
        status.last_byte    = (idx_reg == wrfb_pkg::LAST_IDX);
    end

endmodule

@@ rtl/core/wrfb_ctrl.sv @@
// Controller state machine: sequences update arithmetic and frame output.
// Depends on wrfb_pkg; drives the datapath through cmd_t.
module wrfb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_free,
    input  wrfb_pkg::status_t  status,
    output wrfb_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MUL      = 6'b000010,
        ST_CHECK    = 6'b000100,
        ST_DIV_REV  = 6'b001000,
        ST_SEND     = 6'b010000,
        ST_SETTLE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.is_encode)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (status.room_ok)
                    begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.count_ok)
                begin
                    cmd.start_rev = 1'b1;
                    state_next    = ST_DIV_REV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_REV:
            begin
                if (!status.div_busy)
                begin
                    cmd.add_rev  = 1'b1;
                    cmd.add_tick = 1'b1;
                    state_next   = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_IDLE;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    cmd.send = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
